/* rtl/core/hrd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_pkg
// Shared types and constants of the HTTP response header deframer.
// ----------------------------------------------------------------------------
package hrd_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned OUT_LEN_W       = 32;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [3:0] NAME_LEN = 4'd14;

  typedef enum logic [2:0] {
    CLS_STATUS   = 3'd0,
    CLS_NAME     = 3'd1,
    CLS_SEP      = 3'd2,
    CLS_VALUE    = 3'd3,
    CLS_LINE_END = 3'd4,
    CLS_BODY     = 3'd5,
    CLS_TRAIL    = 3'd6
  } byte_class_e;

  // per-byte flags worked out by the front end
  typedef struct packed {
    logic is_colon;
    logic is_lf;
    logic is_cr;
    logic is_space;
    logic is_digit;
    logic is_plus;
    logic is_minus;
  } byte_info_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    byte_info_t info;
  } hrd_entry_t;

  // "Content-Length", one character per position
  function automatic logic [7:0] name_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h43; // C
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h4C; // L
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/core/hrd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_if
// Valid/ready channels of the deframer: incoming bytes and labeled words.
// ----------------------------------------------------------------------------
interface hrd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface hrd_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [2:0]  byte_class;
  logic        headers_done;
  logic        length_seen;
  logic [31:0] body_length;
  logic        body_last;
  logic        message_done;

  modport source (
    output valid, output byte_out, output byte_class, output headers_done,
    output length_seen, output body_length, output body_last,
    output message_done, input ready
  );
  modport sink (
    input valid, input byte_out, input byte_class, input headers_done,
    input length_seen, input body_length, input body_last,
    input message_done, output ready
  );
endinterface

/* rtl/core/hrd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_front
// Accepts input words and tags each byte with its character classes.
// ----------------------------------------------------------------------------
module hrd_front
  import hrd_pkg::*;
(
  hrd_byte_if.sink   byte_i,
  output logic       push_valid_o,
  output hrd_entry_t push_entry_o,
  input  logic       push_ready_i
);

  logic [7:0] ch;
  byte_info_t info;

  assign ch = byte_i.data_byte;

  always_comb begin
    info.is_colon = (ch == CH_COLON);
    info.is_lf    = (ch == CH_LF);
    info.is_cr    = (ch == CH_CR);
    info.is_space = (ch inside {[8'h09:8'h0D], 8'h20});
    info.is_digit = (ch inside {[8'h30:8'h39]});
    info.is_plus  = (ch == CH_PLUS);
    info.is_minus = (ch == CH_MINUS);
  end

  assign byte_i.ready           = push_ready_i;
  assign push_valid_o           = byte_i.valid;
  assign push_entry_o.data_byte = ch;
  assign push_entry_o.restart   = byte_i.restart;
  assign push_entry_o.info      = info;

endmodule

/* rtl/core/hrd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_queue
// Short FIFO between the classifying front end and the parser.
// ----------------------------------------------------------------------------
module hrd_queue
  import hrd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  input  hrd_entry_t push_entry_i,
  output logic       push_ready_o,
  output logic       pop_valid_o,
  output hrd_entry_t pop_entry_o,
  input  logic       pop_ready_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  hrd_entry_t      mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

/* rtl/core/hrd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_back
// Header/body parser: tracks line state, matches Content-Length, converts
// its value, counts the body and drives the registered result word.
// ----------------------------------------------------------------------------
module hrd_back
  import hrd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         pop_valid_i,
  input  hrd_entry_t   pop_entry_i,
  output logic         pop_ready_o,
  hrd_result_if.source result_o
);

  localparam int unsigned LB = LENGTH_BITS;

  typedef enum logic [1:0] {
    PH_STATUS,
    PH_HEADER,
    PH_BODY,
    PH_TRAIL
  } phase_e;

  typedef enum logic [1:0] {
    NP_LEAD,
    NP_SIGN,
    NP_DIGITS,
    NP_DONE
  } num_phase_e;

  phase_e     phase_q, phase_d, c_phase;
  num_phase_e np_q, np_d, c_np;
  logic       prev_cr_q, prev_cr_d, c_prev_cr;
  logic       first_q, first_d, c_first;
  logic       empty_name_q, empty_name_d, c_empty_name;
  logic       cr_only_q, cr_only_d, c_cr_only;
  logic       colon_q, colon_d, c_colon;
  logic       skip_q, skip_d, c_skip;
  logic [3:0] pos_q, pos_d, c_pos;
  logic       match_ok_q, match_ok_d, c_match_ok;
  logic       neg_q, neg_d, c_neg;
  logic [LB-1:0] acc_q, acc_d, c_acc;
  logic [LB-1:0] len_q, len_d, c_len;
  logic       flag_q, flag_d, c_flag;
  logic [LB-1:0] rem_q, rem_d, c_rem, rem_dec;

  logic [LB+3:0]        acc_x10;
  logic [LB+OUT_LEN_W-1:0] len_ext;
  logic                 fire, in_hdr, line_end, last, done;
  byte_class_e          cls;
  byte_info_t           info;
  logic [7:0]           ch;

  // result register
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic [2:0]  out_class_q;
  logic        out_hdone_q, out_seen_q, out_last_q, out_done_q;
  logic [31:0] out_len_q;

  assign fire        = pop_valid_i && (!out_valid_q || result_o.ready);
  assign pop_ready_o = !out_valid_q || result_o.ready;
  assign info        = pop_entry_i.info;
  assign ch          = pop_entry_i.data_byte;

  // restart clears the state before the byte is taken
  always_comb begin
    c_phase      = phase_q;
    c_np         = np_q;
    c_prev_cr    = prev_cr_q;
    c_first      = first_q;
    c_empty_name = empty_name_q;
    c_cr_only    = cr_only_q;
    c_colon      = colon_q;
    c_skip       = skip_q;
    c_pos        = pos_q;
    c_match_ok   = match_ok_q;
    c_neg        = neg_q;
    c_acc        = acc_q;
    c_len        = len_q;
    c_flag       = flag_q;
    c_rem        = rem_q;
    if (pop_entry_i.restart) begin
      c_phase      = PH_STATUS;
      c_np         = NP_LEAD;
      c_prev_cr    = 1'b0;
      c_first      = 1'b1;
      c_empty_name = 1'b0;
      c_cr_only    = 1'b0;
      c_colon      = 1'b0;
      c_skip       = 1'b0;
      c_pos        = '0;
      c_match_ok   = 1'b1;
      c_neg        = 1'b0;
      c_acc        = '0;
      c_len        = '0;
      c_flag       = 1'b0;
      c_rem        = '0;
    end
  end

  // acc*10 + digit; a carry above LB bits means saturation
  assign acc_x10 = ({4'b0, c_acc} << 3) + ({4'b0, c_acc} << 1)
                 + {{LB{1'b0}}, ch[3:0]};
  assign rem_dec = (c_rem != '0) ? c_rem - 1'b1 : c_rem;
  assign in_hdr   = (c_phase == PH_HEADER);
  assign line_end = info.is_lf && c_prev_cr;

  always_comb begin
    phase_d      = c_phase;
    np_d         = c_np;
    prev_cr_d    = c_prev_cr;
    first_d      = c_first;
    empty_name_d = c_empty_name;
    cr_only_d    = c_cr_only;
    colon_d      = c_colon;
    skip_d       = c_skip;
    pos_d        = c_pos;
    match_ok_d   = c_match_ok;
    neg_d        = c_neg;
    acc_d        = c_acc;
    len_d        = c_len;
    flag_d       = c_flag;
    rem_d        = c_rem;
    cls          = CLS_STATUS;
    last         = 1'b0;
    done         = 1'b0;

    case (c_phase)
      PH_BODY: begin
        cls   = CLS_BODY;
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          last    = 1'b1;
          done    = 1'b1;
          phase_d = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        cls = CLS_TRAIL;
      end
      default: begin
        if (!c_colon && info.is_colon) begin
          colon_d = 1'b1;
          skip_d  = 1'b1;
          if (c_first) begin
            empty_name_d = 1'b1;
          end
          cls = in_hdr ? CLS_SEP : CLS_STATUS;
        end else if (line_end) begin
          cls = CLS_LINE_END;
          if (c_empty_name || c_cr_only) begin
            // blank line: header section is over
            rem_d = c_len;
            if (c_len == '0) begin
              phase_d = PH_TRAIL;
              done    = 1'b1;
            end else begin
              phase_d = PH_BODY;
            end
          end else begin
            if (in_hdr && c_colon && c_match_ok && c_pos == NAME_LEN) begin
              len_d  = c_neg ? '0 : c_acc;
              flag_d = 1'b1;
            end
            phase_d = PH_HEADER;
          end
        end else if (c_skip) begin
          skip_d = 1'b0;
          cls    = in_hdr ? CLS_SEP : CLS_STATUS;
        end else if (c_colon) begin
          cls = in_hdr ? CLS_VALUE : CLS_STATUS;
          if (c_np != NP_DONE) begin
            if (c_np == NP_LEAD && !info.is_digit) begin
              if (info.is_plus || info.is_minus) begin
                neg_d = info.is_minus;
                np_d  = NP_SIGN;
              end else if (!info.is_space) begin
                np_d = NP_DONE;
              end
            end else if (!info.is_digit) begin
              np_d = NP_DONE;
            end else begin
              acc_d = (acc_x10[LB+3:LB] != 4'b0) ? '1 : acc_x10[LB-1:0];
              np_d  = NP_DIGITS;
            end
          end
        end else begin
          cls = in_hdr ? CLS_NAME : CLS_STATUS;
          if (c_pos < NAME_LEN && ch == name_char(c_pos)) begin
            pos_d = c_pos + 1'b1;
          end else begin
            match_ok_d = 1'b0;
          end
        end

        if (line_end) begin
          first_d      = 1'b1;
          empty_name_d = 1'b0;
          cr_only_d    = 1'b0;
          colon_d      = 1'b0;
          skip_d       = 1'b0;
          pos_d        = '0;
          match_ok_d   = 1'b1;
          np_d         = NP_LEAD;
          neg_d        = 1'b0;
          acc_d        = '0;
        end else begin
          cr_only_d = c_first && info.is_cr;
          first_d   = 1'b0;
        end
        prev_cr_d = info.is_cr;
      end
    endcase
  end

  assign len_ext = {{OUT_LEN_W{1'b0}}, len_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_STATUS;
      np_q         <= NP_LEAD;
      prev_cr_q    <= 1'b0;
      first_q      <= 1'b1;
      empty_name_q <= 1'b0;
      cr_only_q    <= 1'b0;
      colon_q      <= 1'b0;
      skip_q       <= 1'b0;
      pos_q        <= '0;
      match_ok_q   <= 1'b1;
      neg_q        <= 1'b0;
      acc_q        <= '0;
      len_q        <= '0;
      flag_q       <= 1'b0;
      rem_q        <= '0;
      out_valid_q  <= 1'b0;
      out_byte_q   <= '0;
      out_class_q  <= '0;
      out_hdone_q  <= 1'b0;
      out_seen_q   <= 1'b0;
      out_len_q    <= '0;
      out_last_q   <= 1'b0;
      out_done_q   <= 1'b0;
    end else begin
      if (fire) begin
        phase_q      <= phase_d;
        np_q         <= np_d;
        prev_cr_q    <= prev_cr_d;
        first_q      <= first_d;
        empty_name_q <= empty_name_d;
        cr_only_q    <= cr_only_d;
        colon_q      <= colon_d;
        skip_q       <= skip_d;
        pos_q        <= pos_d;
        match_ok_q   <= match_ok_d;
        neg_q        <= neg_d;
        acc_q        <= acc_d;
        len_q        <= len_d;
        flag_q       <= flag_d;
        rem_q        <= rem_d;
        out_valid_q  <= 1'b1;
        out_byte_q   <= ch;
        out_class_q  <= cls;
        out_hdone_q  <= (phase_d == PH_BODY) || (phase_d == PH_TRAIL);
        out_seen_q   <= flag_d;
        out_len_q    <= len_ext[OUT_LEN_W-1:0];
        out_last_q   <= last;
        out_done_q   <= done;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.byte_out     = out_byte_q;
  assign result_o.byte_class   = out_class_q;
  assign result_o.headers_done = out_hdone_q;
  assign result_o.length_seen  = out_seen_q;
  assign result_o.body_length  = out_len_q;
  assign result_o.body_last    = out_last_q;
  assign result_o.message_done = out_done_q;

`ifndef SYNTHESIS
  // the body phase is left as soon as the count hits zero
  a_body_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> rem_q != '0)
    else $error("body phase with zero bytes remaining");

  a_last_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_done_q && out_hdone_q)
    else $error("final body byte without message completion");

  a_done_after_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_done_q |-> out_hdone_q)
    else $error("message done before header section ended");

  a_fire_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("consumed byte did not produce a result word");

  a_body_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_class_q == CLS_BODY |-> out_hdone_q)
    else $error("body byte before header section ended");
`endif

endmodule

/* rtl/core/http_response_header_deframer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_response_header_deframer_unit
// Labels every byte of an HTTP response and tracks the Content-Length body.
// ----------------------------------------------------------------------------
// Usage:
//   byte_i carries one response byte per word, with restart set on the first
//   byte of a new response. result_o returns one word per byte: the byte, its
//   class, header/length status and body end markers.
//   A byte accepted on byte_i is held in the queue and then in the result register.
//   Throughput: one byte per cycle while result_o is not stalled; the parser's
//   per-byte state update (line state, name match, a x10 add for the length)
//   is combinational.
//   Reset clears the parser to the start of a response and empties the queue;
//   no result is pending afterward.
//   When result_o stalls, the result register holds, the parser stops and the
//   queue fills; byte_i.ready drops once QUEUE_DEPTH bytes are buffered.
// ----------------------------------------------------------------------------
module http_response_header_deframer_unit
  import hrd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hrd_byte_if.sink     byte_i,
  hrd_result_if.source result_o
);

  logic       push_valid, push_ready, pop_valid, pop_ready;
  hrd_entry_t push_entry, pop_entry;

  hrd_front u_front (
    .byte_i       (byte_i),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  hrd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_ready_i  (pop_ready)
  );

  hrd_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_ready_o (pop_ready),
    .result_o    (result_o)
  );

endmodule
